// ----- rtl/rpa_pkg.sv -----
package rpa_pkg;

  localparam int unsigned SINGLE_REGS_DEF = 6;
  localparam int unsigned PAIR_REGS_DEF   = 4;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic POOL_SINGLE = 1'b0;
  localparam logic POOL_PAIR   = 1'b1;

  typedef enum logic [2:0] {
    MODE_ALLOC    = 3'd0,
    MODE_FREE     = 3'd1,
    MODE_FREE_ALL = 3'd2,
    MODE_PUSH     = 3'd3,
    MODE_POP      = 3'd4,
    MODE_CLAIM    = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_BUSY        = 3'd2,
    ST_STACK_FULL  = 3'd3,
    ST_STACK_EMPTY = 3'd4,
    ST_BAD_INDEX   = 3'd5
  } status_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       pool;
    logic [2:0] reg_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] granted_index;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic alloc;
    logic free;
    logic clear;
    logic claim;
    logic load;
  } pool_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

// ----- rtl/rpa_stack_cell.sv -----
module rpa_stack_cell import rpa_pkg::*; #(
  parameter int unsigned W = 10
) (
  input  logic         clk,
  input  stk_ctl_t     ctl,
  input  logic [W-1:0] up_d,
  input  logic [W-1:0] down_d,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.push) begin
      q_nxt = up_d;
    end else if (ctl.pop) begin
      q_nxt = down_d;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- rtl/rpa_pool_map.sv -----
module rpa_pool_map import rpa_pkg::*; #(
  parameter int unsigned N = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  input  pool_ctl_t    ctl,
  input  logic [2:0]   idx,
  input  logic [N-1:0] load_map,
  output logic [N-1:0] map,
  output logic [2:0]   free_idx,
  output logic         has_free,
  output logic         idx_ok,
  output logic         idx_busy
);

  logic [N-1:0] map_r;
  logic [N-1:0] map_nxt;
  logic [N-1:0] mask;
  logic [N-1:0] free_bits;
  logic [N-1:0] low_free;

  assign mask      = N'(1) << idx;
  assign idx_ok    = (32'(idx) < 32'(N));
  assign idx_busy  = |(map_r & mask);
  assign free_bits = ~map_r;
  assign has_free  = |free_bits;
  assign low_free  = free_bits & (map_r + N'(1));

  always_comb begin
    free_idx = 3'd0;
    for (int i = N - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_idx = 3'(i);
      end
    end
  end

  always_comb begin
    map_nxt = map_r;
    if (ctl.clear) begin
      map_nxt = '0;
    end else if (ctl.load) begin
      map_nxt = load_map;
    end else if (ctl.alloc) begin
      map_nxt = map_r | low_free;
    end else if (ctl.free) begin
      map_nxt = map_r & ~mask;
    end else if (ctl.claim) begin
      map_nxt = map_r | mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '0;
    end else begin
      map_r <= map_nxt;
    end
  end

  assign map = map_r;

endmodule

// ----- rtl/register_pool_allocator.sv -----
// Register pool allocator with a context stack.
// Input channel in_valid/in_ready/in_data carries one request: a mode, a pool
// and a register index. Output channel out_valid/out_ready/out_data returns
// exactly one result per request: the granted register index and a status.
// A request is decoded and the bitmaps and stack are updated in the cycle of
// its transfer; the result appears in the output register in the next cycle.
// One request per cycle is sustained while the receiver takes results; the
// bitmap priority encoder is combinational and the stack cells shift on the transfer's clock edge.
// The saved contexts live in a row of STACK_DEPTH cells that shift together,
// so push and pop move every entry by one place toward or away from the top.
// When the receiver stalls, the result stays in the output register and
// in_ready drops until it is taken, so the next request waits upstream.
// Reset clears both busy bitmaps, the stack level and the output valid flag.
// Saved entries are not cleared and are read only after a push wrote them.
// Failed requests leave all state unchanged and report an error status.
module register_pool_allocator import rpa_pkg::*; #(
  parameter int unsigned SINGLE_REGS = SINGLE_REGS_DEF,
  parameter int unsigned PAIR_REGS   = PAIR_REGS_DEF,
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned ENT_W = SINGLE_REGS + PAIR_REGS;
  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1);

  logic             in_fire;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        out_data_nxt;
  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] level_nxt;

  pool_ctl_t        s_ctl;
  pool_ctl_t        p_ctl;
  stk_ctl_t         stk_ctl;

  logic [SINGLE_REGS-1:0] s_map;
  logic [2:0]             s_free_idx;
  logic                   s_has_free;
  logic                   s_idx_ok;
  logic                   s_idx_busy;
  logic [PAIR_REGS-1:0]   p_map;
  logic [2:0]             p_free_idx;
  logic                   p_has_free;
  logic                   p_idx_ok;
  logic                   p_idx_busy;

  logic [2:0]  sel_free_idx;
  logic        sel_has_free;
  logic        sel_idx_ok;
  logic        sel_idx_busy;
  logic        stk_full;
  logic        stk_empty;
  logic        ok_alloc;
  logic        ok_free;
  logic        ok_claim;
  logic        ok_push;
  logic        ok_pop;
  logic        do_clear;

  logic [ENT_W-1:0] cell_q [STACK_DEPTH];
  logic [ENT_W-1:0] top_entry;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sel_free_idx = (in_data.pool == POOL_PAIR) ? p_free_idx : s_free_idx;
  assign sel_has_free = (in_data.pool == POOL_PAIR) ? p_has_free : s_has_free;
  assign sel_idx_ok   = (in_data.pool == POOL_PAIR) ? p_idx_ok   : s_idx_ok;
  assign sel_idx_busy = (in_data.pool == POOL_PAIR) ? p_idx_busy : s_idx_busy;
  assign stk_full     = (level_r == LVL_W'(STACK_DEPTH));
  assign stk_empty    = (level_r == '0);

  assign ok_alloc = in_fire && (in_data.mode == MODE_ALLOC) && sel_has_free;
  assign ok_free  = in_fire && (in_data.mode == MODE_FREE) && sel_idx_ok;
  assign ok_claim = in_fire && (in_data.mode == MODE_CLAIM) && sel_idx_ok && !sel_idx_busy;
  assign ok_push  = in_fire && (in_data.mode == MODE_PUSH) && !stk_full;
  assign ok_pop   = in_fire && (in_data.mode == MODE_POP) && !stk_empty;
  assign do_clear = (in_fire && (in_data.mode == MODE_FREE_ALL)) || ok_push;

  always_comb begin
    s_ctl       = '0;
    p_ctl       = '0;
    s_ctl.clear = do_clear;
    p_ctl.clear = do_clear;
    s_ctl.load  = ok_pop;
    p_ctl.load  = ok_pop;
    if (in_data.pool == POOL_PAIR) begin
      p_ctl.alloc = ok_alloc;
      p_ctl.free  = ok_free;
      p_ctl.claim = ok_claim;
    end else begin
      s_ctl.alloc = ok_alloc;
      s_ctl.free  = ok_free;
      s_ctl.claim = ok_claim;
    end
    stk_ctl.push = ok_push;
    stk_ctl.pop  = ok_pop;
  end

  rpa_pool_map #(
    .N(SINGLE_REGS)
  ) u_single (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (s_ctl),
    .idx      (in_data.reg_index),
    .load_map (top_entry[ENT_W-1:PAIR_REGS]),
    .map      (s_map),
    .free_idx (s_free_idx),
    .has_free (s_has_free),
    .idx_ok   (s_idx_ok),
    .idx_busy (s_idx_busy)
  );

  rpa_pool_map #(
    .N(PAIR_REGS)
  ) u_pair (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (p_ctl),
    .idx      (in_data.reg_index),
    .load_map (top_entry[PAIR_REGS-1:0]),
    .map      (p_map),
    .free_idx (p_free_idx),
    .has_free (p_has_free),
    .idx_ok   (p_idx_ok),
    .idx_busy (p_idx_busy)
  );

  assign top_entry = cell_q[0];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ENT_W-1:0] up_d;
    logic [ENT_W-1:0] down_d;
    if (i == 0) begin : g_first
      assign up_d = {s_map, p_map};
    end else begin : g_mid_up
      assign up_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_d = cell_q[i];
    end else begin : g_mid_down
      assign down_d = cell_q[i+1];
    end
    rpa_stack_cell #(
      .W(ENT_W)
    ) u_cell (
      .clk    (clk),
      .ctl    (stk_ctl),
      .up_d   (up_d),
      .down_d (down_d),
      .q      (cell_q[i])
    );
  end

  always_comb begin
    level_nxt = level_r;
    if (ok_push) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (ok_pop) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_comb begin
    out_data_nxt               = out_data_r;
    out_data_nxt.granted_index = 3'd0;
    out_data_nxt.status        = ST_OK;
    unique case (in_data.mode)
      MODE_ALLOC: begin
        if (sel_has_free) begin
          out_data_nxt.granted_index = sel_free_idx;
        end else begin
          out_data_nxt.status = ST_FULL;
        end
      end
      MODE_FREE: begin
        if (!sel_idx_ok) begin
          out_data_nxt.status = ST_BAD_INDEX;
        end
      end
      MODE_PUSH: begin
        if (stk_full) begin
          out_data_nxt.status = ST_STACK_FULL;
        end
      end
      MODE_POP: begin
        if (stk_empty) begin
          out_data_nxt.status = ST_STACK_EMPTY;
        end
      end
      MODE_CLAIM: begin
        if (!sel_idx_ok) begin
          out_data_nxt.status = ST_BAD_INDEX;
        end else if (sel_idx_busy) begin
          out_data_nxt.status = ST_BUSY;
        end else begin
          out_data_nxt.granted_index = in_data.reg_index;
        end
      end
      default: begin
        out_data_nxt.status = ST_OK;
      end
    endcase
    if (!in_fire) begin
      out_data_nxt = out_data_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      level_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.mode == MODE_PUSH) && !stk_full
      |=> (level_r == LVL_W'($past(level_r) + LVL_W'(1))) && (s_map == '0) && (p_map == '0))
    else $error("push did not advance level and clear bitmaps");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.mode == MODE_POP) && stk_empty
      |=> (out_data_r.status == ST_STACK_EMPTY) && (level_r == '0))
    else $error("pop on empty stack not reported");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("transfer without result");
`endif

endmodule

// ----- sim/register_pool_allocator_tb.sv -----
module register_pool_allocator_tb import rpa_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int RANDOM_ITEMS  = 850;
  localparam int STALL_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 250;
  localparam int HOLD_AFTER    = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [SINGLE_REGS_DEF-1:0] singles;
    logic [PAIR_REGS_DEF-1:0]   pairs;
  } context_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  pending_reqs[$];
  out_item_t expected_grants[$];

  logic [SINGLE_REGS_DEF-1:0] single_map = '0;
  logic [PAIR_REGS_DEF-1:0]   pair_map = '0;
  context_t                   ctx_stack[STACK_DEPTH_DEF];
  int unsigned                ctx_depth = 0;
  int unsigned                deepest_ctx = 0;

  int  reqs_queued = 0;
  int  reqs_sent = 0;
  int  results_checked = 0;
  int  mismatches = 0;
  int  status_seen[8];
  int  idle_cycles = 0;
  logic in_taken = 1'b0;

  int  burst_left = 1;
  int  gap_left = 0;
  int  rx_style = 0;
  int  rx_left = 0;
  int  rx_phase = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  register_pool_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t grant_for(in_item_t req);
    out_item_t   res;
    logic [7:0]  map;
    int unsigned lim;
    bit          touched;
    int          i;
    res.granted_index = '0;
    res.status = ST_OK;
    touched = 1'b0;
    lim = (req.pool == POOL_PAIR) ? PAIR_REGS_DEF : SINGLE_REGS_DEF;
    map = (req.pool == POOL_PAIR) ? 8'(pair_map) : 8'(single_map);
    case (req.mode)
      MODE_ALLOC: begin
        res.status = ST_FULL;
        for (i = 0; i < lim; i++) begin
          if (!map[i] && res.status == ST_FULL) begin
            map[i] = 1'b1;
            res.granted_index = 3'(i);
            res.status = ST_OK;
          end
        end
        touched = 1'b1;
      end
      MODE_FREE: begin
        if (req.reg_index >= lim) begin
          res.status = ST_BAD_INDEX;
        end else begin
          map[req.reg_index] = 1'b0;
          touched = 1'b1;
        end
      end
      MODE_CLAIM: begin
        if (req.reg_index >= lim) begin
          res.status = ST_BAD_INDEX;
        end else if (map[req.reg_index]) begin
          res.status = ST_BUSY;
        end else begin
          map[req.reg_index] = 1'b1;
          res.granted_index = req.reg_index;
          touched = 1'b1;
        end
      end
      MODE_FREE_ALL: begin
        single_map = '0;
        pair_map = '0;
      end
      MODE_PUSH: begin
        if (ctx_depth >= STACK_DEPTH_DEF) begin
          res.status = ST_STACK_FULL;
        end else begin
          ctx_stack[ctx_depth] = '{singles: single_map, pairs: pair_map};
          ctx_depth++;
          single_map = '0;
          pair_map = '0;
        end
      end
      MODE_POP: begin
        if (ctx_depth == 0) begin
          res.status = ST_STACK_EMPTY;
        end else begin
          ctx_depth--;
          single_map = ctx_stack[ctx_depth].singles;
          pair_map = ctx_stack[ctx_depth].pairs;
        end
      end
      default: begin
      end
    endcase
    if (touched) begin
      if (req.pool == POOL_PAIR) pair_map = map[PAIR_REGS_DEF-1:0];
      else single_map = map[SINGLE_REGS_DEF-1:0];
    end
    if (ctx_depth > deepest_ctx) deepest_ctx = ctx_depth;
    return res;
  endfunction

  task automatic add_req(logic [2:0] mode, logic pool, logic [2:0] idx);
    in_item_t req;
    req.mode = mode;
    req.pool = pool;
    req.reg_index = idx;
    pending_reqs.push_back(req);
    if (mode != MODE_UNUSED_LO && mode != MODE_UNUSED_HI) reqs_queued++;
  endtask

  function automatic logic [2:0] pick_index(logic pool);
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(0, 7));
    if (pool == POOL_PAIR) return 3'($urandom_range(0, PAIR_REGS_DEF - 1));
    return 3'($urandom_range(0, SINGLE_REGS_DEF - 1));
  endfunction

  task automatic add_mixed_ops(int count);
    int  n;
    int  r;
    logic pool;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      pool = 1'($urandom_range(0, 1));
      if (r < 30) add_req(MODE_ALLOC, pool, 3'($urandom_range(0, 7)));
      else if (r < 50) add_req(MODE_FREE, pool, pick_index(pool));
      else if (r < 68) add_req(MODE_CLAIM, pool, pick_index(pool));
      else if (r < 78) add_req(MODE_PUSH, pool, 3'($urandom_range(0, 7)));
      else if (r < 88) add_req(MODE_POP, pool, 3'($urandom_range(0, 7)));
      else if (r < 95) add_req(MODE_FREE_ALL, pool, 3'($urandom_range(0, 7)));
      else add_req(3'($urandom_range(0, 7)), pool, 3'($urandom_range(0, 7)));
    end
  endtask

  task automatic add_stack_dive(int levels);
    int n;
    for (n = 0; n < levels; n++) begin
      add_mixed_ops($urandom_range(0, 3));
      add_req(MODE_PUSH, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    end
    for (n = 0; n < levels + 2; n++) begin
      add_req(MODE_POP, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      if ($urandom_range(0, 2) == 0) add_mixed_ops(1);
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // The receiver runs its own stall pattern and, once enough traffic has passed,
  // holds off for a long stretch so that the block backs up into its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && reqs_sent >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_left = $urandom_range(10, 80);
      end
      rx_left--;
      rx_phase++;
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 99) < 55);
        default: out_ready <= (rx_phase % 4 != 3);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_grants.push_back(grant_for(in_data));
      reqs_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected transfer: granted_index %0d status %0d",
                   out_data.granted_index, out_data.status);
      end else begin
        want = expected_grants.pop_front();
        results_checked++;
        status_seen[out_data.status]++;
        if (out_data.granted_index !== want.granted_index ||
            out_data.status !== want.status) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d: expected granted_index %0d status %0d, got %0d %0d",
                     results_checked, want.granted_index, want.status,
                     out_data.granted_index, out_data.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", idle_cycles);
      $display("register_pool_allocator regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int directed;
    int r;
    for (r = 0; r < SINGLE_REGS_DEF + 1; r++) add_req(MODE_ALLOC, POOL_SINGLE, 3'd7);
    for (r = 0; r < PAIR_REGS_DEF + 1; r++) add_req(MODE_ALLOC, POOL_PAIR, 3'd0);
    add_req(MODE_CLAIM, POOL_SINGLE, 3'd2);
    add_req(MODE_FREE, POOL_SINGLE, 3'd3);
    add_req(MODE_FREE, POOL_SINGLE, 3'd3);
    add_req(MODE_CLAIM, POOL_SINGLE, 3'd3);
    add_req(MODE_FREE, POOL_PAIR, 3'd7);
    add_req(MODE_CLAIM, POOL_PAIR, 3'd4);
    add_req(MODE_CLAIM, POOL_SINGLE, 3'd6);
    add_req(MODE_POP, POOL_SINGLE, 3'd0);
    add_req(MODE_PUSH, POOL_PAIR, 3'd5);
    add_req(MODE_POP, POOL_SINGLE, 3'd0);
    add_req(MODE_FREE_ALL, POOL_PAIR, 3'd0);
    add_req(MODE_UNUSED_LO, POOL_PAIR, 3'd7);
    add_req(MODE_UNUSED_HI, POOL_SINGLE, 3'd5);
    directed = reqs_queued;
    add_stack_dive(STACK_DEPTH_DEF + 2);
    while (reqs_queued < directed + RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 7) add_mixed_ops($urandom_range(8, 30));
      else if (r < 9) add_stack_dive($urandom_range(10, STACK_DEPTH_DEF + 3));
      else add_mixed_ops($urandom_range(1, 4));
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d mismatches, deepest stack %0d",
             reqs_sent, results_checked, mismatches, deepest_ctx);
    $display("ok %0d, full %0d, busy %0d, stack full %0d, stack empty %0d, bad index %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BUSY],
             status_seen[ST_STACK_FULL], status_seen[ST_STACK_EMPTY],
             status_seen[ST_BAD_INDEX]);
    if (mismatches == 0) begin
      $display("register_pool_allocator regression: pass");
    end else begin
      $display("register_pool_allocator regression: fail");
    end
    $finish;
  end

endmodule
